/* hdl/twsm_pkg.sv */
// ----------------------------------------------------------------------------
// Three-wire serial master: shared types and constants
// Operation codes and the framing constants of the serial link.
// ----------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

   // Operation code carried by each request word.
   typedef logic [1:0] op_type;

   localparam op_type OP_TICK  = 2'd0;
   localparam op_type OP_WRITE = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   // Width of the serial frame and of its bit counter.
   localparam int unsigned FRAME_BITS = 16;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned BYTE_W     = 8;

   typedef logic [COUNT_W-1:0] count_type;

   // The reply byte starts at this frame position.
   localparam count_type REPLY_FIRST_BIT = 5'd8;
   localparam count_type FRAME_END       = 5'd16;

   // Command byte bit that marks a read.
   localparam logic [BYTE_W-1:0] READ_FLAG = 8'h01;

endpackage : twsm_pkg

`default_nettype wire

/* hdl/three_wire_serial_master_unit.sv */
// ----------------------------------------------------------------------------
// Three-wire serial master unit
// Pin sequencer for an enable/clock/data serial link, stepped by one
// request word per timing tick. Write frames send a command and a data byte
// least significant bit first; read frames send the command and sample the
// reply byte while the clock is low.
//
//   Channel  | Direction | Handshake          | Contents
//   ---------+-----------+--------------------+--------------------------------
//   req_     | in        | req_valid/ready    | op, command, data, data pin
//   rsp_     | out       | rsp_valid/ready    | pin levels, status, read byte
//   csr_     | in        | csr_write_enable   | ticks per clock phase
//
// One word is accepted every clock cycle while the result side keeps up.
// A word's result is loaded into the result register as the word leaves the
// input register: the sequencer works combinationally on the input register.
// When the result is not taken, the input register still holds one more
// word and then ready drops. Reset clears the sequencer to idle with the
// clock and enable pins low, and the phase length to one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_serial_master_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire twsm_pkg::op_type   req_op,
   input  wire logic [7:0]         req_reg_address,
   input  wire logic [7:0]         req_write_data,
   input  wire logic               req_data_in,
   // Result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_clk_out,
   output logic                    rsp_dat_out,
   output logic                    rsp_dat_drive,
   output logic                    rsp_ce_out,
   output logic                    rsp_busy_res,
   output logic [7:0]              rsp_read_data,
   output logic                    rsp_read_done,
   output logic                    rsp_cmd_rejected,
   // Configuration
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data
);

   import twsm_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH,
      PH_END
   } phase_type;

   // Input register.
   logic              s1_valid_ff;
   op_type            s1_op_ff;
   logic [7:0]        s1_addr_ff;
   logic [7:0]        s1_wdat_ff;
   logic              s1_din_ff;

   // Sequencer state.
   phase_type         phase_ff, phase_in;
   count_type         bit_count_ff, bit_count_in;
   logic [15:0]       tx_shift_ff, tx_shift_in;
   logic [7:0]        rx_shift_ff, rx_shift_in;
   logic              is_read_ff, is_read_in;
   logic [7:0]        phase_ticks_ff, phase_ticks_in;
   logic              pin_clk_ff, pin_clk_in;
   logic              pin_dat_ff, pin_dat_in;
   logic              pin_drive_ff, pin_drive_in;
   logic              pin_ce_ff, pin_ce_in;
   logic [7:0]        read_hold_ff, read_hold_in;
   logic [7:0]        ticks_per_phase_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_clk_ff, rsp_dat_ff, rsp_drive_ff, rsp_ce_ff, rsp_busy_ff;
   logic [7:0]        rsp_rdata_ff;
   logic              rsp_done_ff, rsp_rej_ff;

   logic              advance;
   logic              start;
   logic              done_in;
   logic              rejected_in;
   logic [7:0]        span;
   logic [7:0]        cmd;
   count_type         next_count;

   // Handshake: the sequencer steps when the result register is free.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // A phase length of zero behaves as one tick.
   assign span  = (ticks_per_phase_ff == 8'd0) ? 8'd1 : ticks_per_phase_ff;
   assign start = (s1_op_ff == OP_WRITE) || (s1_op_ff == OP_READ);
   assign cmd   = (s1_op_ff == OP_READ) ? (s1_addr_ff | READ_FLAG) : s1_addr_ff;
   assign next_count = bit_count_ff + 5'd1;

   // Sequencer next state for the word in the input register.
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      tx_shift_in    = tx_shift_ff;
      rx_shift_in    = rx_shift_ff;
      is_read_in     = is_read_ff;
      phase_ticks_in = phase_ticks_ff;
      pin_clk_in     = pin_clk_ff;
      pin_dat_in     = pin_dat_ff;
      pin_drive_in   = pin_drive_ff;
      pin_ce_in      = pin_ce_ff;
      read_hold_in   = read_hold_ff;
      done_in        = 1'b0;
      rejected_in    = 1'b0;
      if (phase_ff == PH_IDLE) begin
         // A start word is the first tick of the low phase of bit 0.
         if (start) begin
            is_read_in     = (s1_op_ff == OP_READ);
            tx_shift_in    = {s1_wdat_ff, cmd};
            rx_shift_in    = 8'd0;
            bit_count_in   = '0;
            phase_in       = PH_LOW;
            phase_ticks_in = 8'd1;
            pin_clk_in     = 1'b0;
            pin_ce_in      = 1'b1;
            pin_drive_in   = 1'b1;
            pin_dat_in     = cmd[0];
         end
      end else begin
         rejected_in = start;
         if (phase_ticks_ff < span) begin
            phase_ticks_in = phase_ticks_ff + 8'd1;
         end else begin
            phase_ticks_in = 8'd1;
            case (phase_ff)
               PH_LOW: begin
                  // Reply bits are sampled as the low phase ends.
                  if (is_read_ff && (bit_count_ff >= REPLY_FIRST_BIT)) begin
                     rx_shift_in[bit_count_ff[2:0]] = s1_din_ff;
                  end
                  phase_in   = PH_HIGH;
                  pin_clk_in = 1'b1;
               end
               PH_HIGH: begin
                  bit_count_in = next_count;
                  if (next_count >= FRAME_END) begin
                     phase_in   = PH_END;
                     pin_clk_in = 1'b0;
                  end else begin
                     phase_in   = PH_LOW;
                     pin_clk_in = 1'b0;
                     pin_ce_in  = 1'b1;
                     if (is_read_ff && (next_count >= REPLY_FIRST_BIT)) begin
                        pin_drive_in = 1'b0;
                        pin_dat_in   = 1'b0;
                     end else begin
                        pin_drive_in = 1'b1;
                        pin_dat_in   = tx_shift_ff[next_count[3:0]];
                     end
                  end
               end
               PH_END: begin
                  if (is_read_ff) begin
                     read_hold_in = rx_shift_ff;
                     done_in      = 1'b1;
                  end
                  phase_in       = PH_IDLE;
                  phase_ticks_in = 8'd0;
                  pin_clk_in     = 1'b0;
                  pin_dat_in     = 1'b0;
                  pin_drive_in   = 1'b1;
                  pin_ce_in      = 1'b0;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // State, input register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         phase_ff           <= PH_IDLE;
         bit_count_ff       <= '0;
         tx_shift_ff        <= 16'd0;
         rx_shift_ff        <= 8'd0;
         is_read_ff         <= 1'b0;
         phase_ticks_ff     <= 8'd0;
         pin_clk_ff         <= 1'b0;
         pin_dat_ff         <= 1'b0;
         pin_drive_ff       <= 1'b1;
         pin_ce_ff          <= 1'b0;
         read_hold_ff       <= 8'd0;
         ticks_per_phase_ff <= 8'd1;
      end else begin
         if (csr_write_enable) begin
            ticks_per_phase_ff <= csr_write_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         // A new result replaces the one taken in the same cycle.
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff       <= phase_in;
            bit_count_ff   <= bit_count_in;
            tx_shift_ff    <= tx_shift_in;
            rx_shift_ff    <= rx_shift_in;
            is_read_ff     <= is_read_in;
            phase_ticks_ff <= phase_ticks_in;
            pin_clk_ff     <= pin_clk_in;
            pin_dat_ff     <= pin_dat_in;
            pin_drive_ff   <= pin_drive_in;
            pin_ce_ff      <= pin_ce_in;
            read_hold_ff   <= read_hold_in;
         end
      end
      // Payload registers.
      if (req_ready && req_valid) begin
         s1_op_ff   <= req_op;
         s1_addr_ff <= req_reg_address;
         s1_wdat_ff <= req_write_data;
         s1_din_ff  <= req_data_in;
      end
      if (advance) begin
         rsp_clk_ff   <= pin_clk_in;
         rsp_dat_ff   <= pin_drive_in & pin_dat_in;
         rsp_drive_ff <= pin_drive_in;
         rsp_ce_ff    <= pin_ce_in;
         rsp_busy_ff  <= (phase_in != PH_IDLE);
         rsp_rdata_ff <= read_hold_in;
         rsp_done_ff  <= done_in;
         rsp_rej_ff   <= rejected_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clk_out      = rsp_clk_ff;
   assign rsp_dat_out      = rsp_dat_ff;
   assign rsp_dat_drive    = rsp_drive_ff;
   assign rsp_ce_out       = rsp_ce_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_read_done    = rsp_done_ff;
   assign rsp_cmd_rejected = rsp_rej_ff;

   // Enable is high exactly while a frame is in progress.
   a_ce_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == !pin_ce_ff)
      else $error("enable pin disagrees with sequencer phase");

   // The data pin is released only during the reply byte of a read.
   a_release_in_reply: assert property (@(posedge clock) disable iff (reset)
      !pin_drive_ff |-> (is_read_ff && (bit_count_ff >= REPLY_FIRST_BIT)))
      else $error("data pin released outside a read reply");

   // The bit counter never passes the end of the frame.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= FRAME_END)
      else $error("bit counter beyond frame end");

   // A finished read is reported with the sequencer already idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("read completion reported while busy");

   // Every step of the sequencer leaves a result waiting.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("sequencer step produced no result");

endmodule : three_wire_serial_master_unit

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Three-wire serial master unit: self-checking testbench
// Words are sent through the request channel from a queue, each result word
// is compared with the pin levels, status and read byte from a behavioural
// model of the link sequencer; the phase length changes between runs of frames.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import twsm_pkg::*;

   // The fourth op code is unused and behaves as a plain tick.
   localparam op_type OP_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 300;
   localparam int LONG_PHASE_TICKS = 260;

   typedef enum logic [2:0] {LINK_IDLE, LINK_LOW, LINK_HIGH, LINK_END} link_phase_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] addr;
      logic [7:0] wdat;
      logic       din;
   } link_word_type;

   typedef struct packed {
      logic       clk;
      logic       dat;
      logic       drive;
      logic       ce;
      logic       busy;
      logic [7:0] rdata;
      logic       done;
      logic       rejected;
   } link_levels_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   op_type     req_op = OP_TICK;
   logic [7:0] req_reg_address = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       req_data_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_clk_out;
   logic       rsp_dat_out;
   logic       rsp_dat_drive;
   logic       rsp_ce_out;
   logic       rsp_busy_res;
   logic [7:0] rsp_read_data;
   logic       rsp_read_done;
   logic       rsp_cmd_rejected;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   three_wire_serial_master_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_address  (req_reg_address),
      .req_write_data   (req_write_data),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_clk_out      (rsp_clk_out),
      .rsp_dat_out      (rsp_dat_out),
      .rsp_dat_drive    (rsp_dat_drive),
      .rsp_ce_out       (rsp_ce_out),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_done    (rsp_read_done),
      .rsp_cmd_rejected (rsp_cmd_rejected),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Model state of the link sequencer and its phase length.
   link_phase_type link_phase;
   count_type   frame_pos;
   logic [15:0] frame_bits;
   logic [7:0]  reply_bits;
   logic        reading;
   logic [7:0]  tick_count;
   logic [7:0]  phase_len;
   logic [7:0]  reply_held;
   logic        pin_clk, pin_dat, pin_drive, pin_ce;

   link_word_type   pending_words[$];
   link_levels_type expected_levels[$];

   int  mismatch_count = 0;
   int  levels_seen = 0;
   int  send_gap = 0;
   int  send_burst;
   int  take_gap = 0;
   int  take_burst;
   int  hold_left = 0;
   int  idle_cycles = 0;
   int  quiet_left[2] = '{0, 0};
   bit  calm = 1'b0;
   link_word_type   next_word;
   link_levels_type got_levels;
   link_levels_type want_levels;

   initial begin
      forever #1 clock = ~clock;
   end

   // Set up the pins for the low half of the current frame bit.
   function automatic void drive_low_phase();
      pin_clk = 1'b0;
      pin_ce  = 1'b1;
      if (reading && frame_pos >= REPLY_FIRST_BIT) begin
         pin_drive = 1'b0;
         pin_dat   = 1'b0;
      end else begin
         pin_drive = 1'b1;
         pin_dat   = frame_bits[frame_pos[3:0]];
      end
   endfunction

   function automatic void release_link();
      link_phase = LINK_IDLE;
      tick_count = 8'd0;
      pin_clk    = 1'b0;
      pin_dat    = 1'b0;
      pin_drive  = 1'b1;
      pin_ce     = 1'b0;
   endfunction

   // Advance the model by one word and return the pin levels that follow.
   function automatic link_levels_type advance_link(op_type op, logic [7:0] addr,
                                                    logic [7:0] wdat, logic din);
      logic            start;
      logic            rejected;
      logic            done;
      logic [7:0]      span;
      logic [7:0]      cmd;
      logic [2:0]      reply_idx;
      link_levels_type levels;
      start     = (op == OP_WRITE) || (op == OP_READ);
      rejected  = 1'b0;
      done      = 1'b0;
      span      = (phase_len == 8'd0) ? 8'd1 : phase_len;
      cmd       = addr;
      reply_idx = 3'(frame_pos - REPLY_FIRST_BIT);
      if (link_phase == LINK_IDLE) begin
         if (start) begin
            reading = (op == OP_READ);
            if (reading)
               cmd = cmd | READ_FLAG;
            frame_bits = {wdat, cmd};
            reply_bits = 8'h00;
            frame_pos  = '0;
            link_phase = LINK_LOW;
            tick_count = 8'd1;
            drive_low_phase();
         end
      end else begin
         rejected = start;
         if (tick_count < span) begin
            tick_count++;
         end else begin
            tick_count = 8'd1;
            case (link_phase)
               LINK_LOW: begin
                  // The reply bit is taken as the low half ends.
                  if (reading && frame_pos >= REPLY_FIRST_BIT && frame_pos < FRAME_END)
                     reply_bits[reply_idx] = din;
                  link_phase = LINK_HIGH;
                  pin_clk    = 1'b1;
               end
               LINK_HIGH: begin
                  frame_pos++;
                  if (frame_pos >= FRAME_END) begin
                     link_phase = LINK_END;
                     pin_clk    = 1'b0;
                  end else begin
                     link_phase = LINK_LOW;
                     drive_low_phase();
                  end
               end
               default: begin
                  if (reading) begin
                     reply_held = reply_bits;
                     done       = 1'b1;
                  end
                  release_link();
               end
            endcase
         end
      end
      levels.clk      = pin_clk;
      levels.dat      = pin_drive ? pin_dat : 1'b0;
      levels.drive    = pin_drive;
      levels.ce       = pin_ce;
      levels.busy     = (link_phase != LINK_IDLE);
      levels.rdata    = reply_held;
      levels.done     = done;
      levels.rejected = rejected;
      return levels;
   endfunction

   // Length of an idle burst for one side; zero means no idling now.
   function automatic int idle_burst(int side);
      if (calm)
         return 0;
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_left[side] = $urandom_range(20, 80);
         return 0;
      end
      if ($urandom_range(0, 5) == 0)
         return $urandom_range(1, 9);
      return 0;
   endfunction

   task automatic report_mismatch(string what, link_levels_type want, link_levels_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected clk=%b dat=%b drv=%b ce=%b busy=%b rd=%02h done=%b rej=%b, ",
                  what, want.clk, want.dat, want.drive, want.ce, want.busy, want.rdata,
                  want.done, want.rejected,
                  "got clk=%b dat=%b drv=%b ce=%b busy=%b rd=%02h done=%b rej=%b",
                  got.clk, got.dat, got.drive, got.ce, got.busy, got.rdata,
                  got.done, got.rejected);
   endtask

   task automatic queue_word(op_type op, logic [7:0] addr, logic [7:0] wdat, logic din);
      link_word_type w;
      w.op   = op;
      w.addr = addr;
      w.wdat = wdat;
      w.din  = din;
      pending_words.push_back(w);
   endtask

   // A start word followed by enough ticks to finish the frame, unless cut
   // short. Noise puts starts and spare codes among the ticks.
   task automatic queue_frame(op_type op, logic [7:0] addr, logic [7:0] wdat,
                              int noise, bit cut_short);
      int     span;
      int     ticks;
      op_type tick_op;
      span  = (phase_len == 8'd0) ? 1 : phase_len;
      ticks = (2 * FRAME_BITS + 1) * span + $urandom_range(0, 3);
      if (cut_short)
         ticks = $urandom_range(1, ticks);
      queue_word(op, addr, wdat, 1'($urandom_range(0, 1)));
      repeat (ticks) begin
         if ($urandom_range(0, 99) < noise)
            tick_op = op_type'($urandom_range(1, 3));
         else
            tick_op = OP_TICK;
         queue_word(tick_op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_random_frames(int count, int noise);
      repeat (count)
         queue_frame($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     noise, $urandom_range(0, 7) == 0);
   endtask

   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_levels.size() != 0);
   endtask

   // Write the phase length once no word is in flight.
   task automatic write_phase_length(logic [7:0] len);
      wait_until_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      phase_len = len;
   endtask

   // Let the sequencer run back to idle, then write the phase length.
   task automatic set_phase_length(logic [7:0] len);
      wait_until_drained();
      while (link_phase != LINK_IDLE) begin
         repeat (16)
            queue_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
         wait_until_drained();
      end
      write_phase_length(len);
   endtask

   // Stimulus sequence.
   initial begin
      phase_len  = 8'd1;
      frame_pos  = '0;
      frame_bits = 16'h0000;
      reply_bits = 8'h00;
      reading    = 1'b0;
      reply_held = 8'h00;
      release_link();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset phase length.
      queue_word(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
      queue_word(OP_TICK, 8'h00, 8'h00, 1'b0);
      queue_frame(OP_WRITE, 8'hFF, 8'h00, 0, 1'b0);
      queue_frame(OP_READ, 8'h00, 8'hFF, 0, 1'b0);
      queue_frame(OP_WRITE, 8'h00, 8'hFF, 0, 1'b0);
      queue_frame(OP_READ, 8'hFE, 8'h00, 0, 1'b0);
      // A read start, then starts and the spare code while its frame is under way.
      queue_word(OP_READ, 8'hAA, 8'h55, 1'b1);
      queue_word(OP_WRITE, 8'h55, 8'hAA, 1'b0);
      queue_word(OP_SPARE, 8'h00, 8'h00, 1'b1);
      queue_word(OP_READ, 8'hFF, 8'hFF, 1'b0);

      // A zero phase length behaves as one tick.
      set_phase_length(8'd0);
      run_random_frames(4, 6);
      set_phase_length(8'd2);
      run_random_frames(2, 6);

      // The longest phase: a read runs through its first low phase, and the
      // phase length is then shortened while the frame is still under way.
      set_phase_length(8'd255);
      queue_word(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      repeat (LONG_PHASE_TICKS)
         queue_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      write_phase_length(8'd3);
      run_random_frames(2, 6);

      // Closing run with no idling on either side.
      set_phase_length(8'd1);
      calm = 1'b1;
      run_random_frames(5, 6);

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Request driver: one word from the queue per handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_levels.push_back(advance_link(req_op, req_reg_address,
                                                   req_write_data, req_data_in));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               send_burst = idle_burst(0);
               if (send_burst > 0) begin
                  send_gap  = send_burst - 1;
                  req_valid <= 1'b0;
               end else begin
                  next_word = pending_words.pop_front();
                  req_valid       <= 1'b1;
                  req_op          <= next_word.op;
                  req_reg_address <= next_word.addr;
                  req_write_data  <= next_word.wdat;
                  req_data_in     <= next_word.din;
               end
            end
         end
      end
   end

   // Result monitor: checks each word taken and paces rsp_ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_levels = {rsp_clk_out, rsp_dat_out, rsp_dat_drive, rsp_ce_out, rsp_busy_res,
                          rsp_read_data, rsp_read_done, rsp_cmd_rejected};
            if (expected_levels.size() == 0) begin
               report_mismatch("result word with nothing outstanding", '0, got_levels);
            end else begin
               want_levels = expected_levels.pop_front();
               if (got_levels.clk !== want_levels.clk || got_levels.dat !== want_levels.dat ||
                   got_levels.drive !== want_levels.drive || got_levels.ce !== want_levels.ce ||
                   got_levels.busy !== want_levels.busy ||
                   got_levels.rdata !== want_levels.rdata ||
                   got_levels.done !== want_levels.done ||
                   got_levels.rejected !== want_levels.rejected)
                  report_mismatch($sformatf("result word %0d differs", levels_seen),
                                  want_levels, got_levels);
            end
            levels_seen++;
            // Long hold-offs let the block fill up and stall its input.
            if (levels_seen == 400 || levels_seen == 1000)
               hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            take_burst = idle_burst(1);
            if (take_burst > 0) begin
               take_gap  = take_burst - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
hdl/twsm_pkg.sv
hdl/three_wire_serial_master_unit.sv
bench/testbench.sv
